>>> rtl/vgfs_pkg.sv
`default_nettype none

package vgfs_pkg;

    // default sizing of the grid and the value datapath
    localparam int VGFS_MAX_DIM    = 64;
    localparam int VGFS_VALUE_BITS = 32;

    // fixed field widths
    localparam int DIM_REG_W  = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int COORD_W    = 16;
    localparam int FRAC_W     = 16;
    localparam int LOAD_IDX_W = 18;
    localparam int LOAD_VAL_W = 32;
    localparam int SAMPLE_W   = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER = 2'd3;

    // reset values of the configuration registers
    localparam logic [DIM_REG_W-1:0] DIM_RESET    = 7'd64;
    localparam logic                 FILTER_RESET = 1'b1;

    // request commands
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // one half cell in Q.16
    localparam int HALF_CELL = 32768;

    // second operand width of the shared multiplier
    localparam int MUL_B_W = 18;

    // digit-serial divide by three: digit width and reciprocal 43/128
    localparam int DIV_DIGIT_W      = 4;
    localparam int DIV3_RECIP       = 43;
    localparam int DIV3_RECIP_SHIFT = 7;

endpackage

`default_nettype wire

>>> rtl/vgfs_mul.sv
`default_nettype none

module vgfs_mul
    import vgfs_pkg::*;
#(
    parameter int A_W = VGFS_VALUE_BITS + 2,
    parameter int B_W = MUL_B_W
)
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic signed [A_W-1:0]    a,
    input  wire logic signed [B_W-1:0]    b,
    output logic signed [A_W+B_W-1:0]     prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    // registered signed product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> rtl/vgfs_div3.sv
`default_nettype none

module vgfs_div3
    import vgfs_pkg::*;
#(
    parameter int VALUE_BITS = VGFS_VALUE_BITS
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic signed [VALUE_BITS+1:0] dividend,
    output logic                             done,
    output logic signed [VALUE_BITS-1:0]     quotient
);

    localparam int IN_W  = VALUE_BITS + 2;
    localparam int DIV_W = ((IN_W + DIV_DIGIT_W - 1) / DIV_DIGIT_W) * DIV_DIGIT_W;
    localparam int NDIG  = DIV_W / DIV_DIGIT_W;
    localparam int CNT_W = $clog2(NDIG);
    localparam int VAL_W = DIV_DIGIT_W + 2;
    localparam int PR_W  = VAL_W + 6;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0] num_reg;
    logic [DIV_W-1:0] q_reg;
    logic [1:0]       rem_reg;

    logic signed [IN_W:0]   biased;
    logic [VAL_W-1:0]       digit_val;
    logic [PR_W-1:0]        recip_prod;
    logic [DIV_DIGIT_W-1:0] q_digit;
    logic [VAL_W-1:0]       r_full;

    // bias by three times the half range so the dividend is never negative
    assign biased = (IN_W + 1)'(dividend) + ((IN_W + 1)'(3) <<< (VALUE_BITS - 1));

    // one quotient digit: remainder joined with the next dividend digit
    assign digit_val  = {rem_reg, num_reg[DIV_W-1 -: DIV_DIGIT_W]};
    assign recip_prod = PR_W'(digit_val) * PR_W'(DIV3_RECIP);
    assign q_digit    = DIV_DIGIT_W'(recip_prod >> DIV3_RECIP_SHIFT);
    assign r_full     = digit_val - (VAL_W'(q_digit) + VAL_W'({q_digit, 1'b0}));

    // sequencing of the digit steps
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NDIG - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // dividend, remainder and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= DIV_W'(biased);
            rem_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            num_reg <= num_reg << DIV_DIGIT_W;
            rem_reg <= r_full[1:0];
            q_reg   <= {q_reg[DIV_W-DIV_DIGIT_W-1:0], q_digit};
        end
    end

    // remove the bias: subtracting half range flips the top bit
    assign quotient = {~q_reg[VALUE_BITS-1], q_reg[VALUE_BITS-2:0]};
    assign done     = done_reg;

endmodule

`default_nettype wire

>>> rtl/voxel_grid_filtered_sampler.sv
// load request: written in the accept cycle, ready again the next cycle, no result
// sample request, filter off: result register loaded after the centre store read
// sample request, filter on: three axis lerps then a divide by three, using the
//   shared multiplier sequence, up to four single-port store reads and the
//   4-bit-per-cycle divide by three; one request in flight at a time
// reset: control cleared, dims 64, filter on; store contents undefined until loaded
`default_nettype none

module voxel_grid_filtered_sampler
    import vgfs_pkg::*;
#(
    parameter int MAX_DIM    = VGFS_MAX_DIM,
    parameter int VALUE_BITS = VGFS_VALUE_BITS
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic                         command,
    input  wire logic [LOAD_IDX_W-1:0]        load_index,
    input  wire logic signed [LOAD_VAL_W-1:0] load_value,
    input  wire logic [COORD_W-1:0]           coord_u,
    input  wire logic [COORD_W-1:0]           coord_v,
    input  wire logic [COORD_W-1:0]           coord_w,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [SAMPLE_W-1:0]        sample_value,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [CFG_DATA_W-1:0]        cfg_data
);

    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int POS_W  = $clog2(MAX_DIM);
    localparam int DEPTH  = MAX_DIM * MAX_DIM * MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MA_W   = VALUE_BITS + 2;
    localparam int MB_W   = MUL_B_W;
    localparam int P_W    = MA_W + MB_W;
    localparam int SUM_W  = VALUE_BITS + 2;
    localparam int CP_W   = COORD_W + DIM_W;
    localparam int T_W    = FRAC_W + 1;

    // sequencer states
    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_MU   = 5'd1;
    localparam logic [4:0] ST_MV   = 5'd2;
    localparam logic [4:0] ST_MW   = 5'd3;
    localparam logic [4:0] ST_MS   = 5'd4;
    localparam logic [4:0] ST_MY   = 5'd5;
    localparam logic [4:0] ST_MZ   = 5'd6;
    localparam logic [4:0] ST_AD   = 5'd7;
    localparam logic [4:0] ST_RC   = 5'd8;
    localparam logic [4:0] ST_CW   = 5'd9;
    localparam logic [4:0] ST_RN   = 5'd10;
    localparam logic [4:0] ST_DF   = 5'd11;
    localparam logic [4:0] ST_ML   = 5'd12;
    localparam logic [4:0] ST_AC   = 5'd13;
    localparam logic [4:0] ST_DV   = 5'd14;
    localparam logic [4:0] ST_DW   = 5'd15;
    localparam logic [4:0] ST_OUT  = 5'd16;

    // axis codes
    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d < DIM_REG_W'(2))
        begin
            r = DIM_W'(2);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = DIM_W'(d);
        end
        return r;
    endfunction

    function automatic logic signed [VALUE_BITS-1:0] sat_load(
        input logic signed [LOAD_VAL_W-1:0] x
    );
        logic signed [63:0] wx;
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        wx = 64'(x);
        hi = (64'sd1 <<< (VALUE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (wx > hi)
        begin
            wx = hi;
        end
        else if (wx < lo)
        begin
            wx = lo;
        end
        return VALUE_BITS'(wx);
    endfunction

    // control registers
    logic [4:0]           state_reg, state_next;
    logic [1:0]           ax_reg, ax_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DIM_REG_W-1:0] dim_x_reg, dim_y_reg, dim_z_reg;
    logic                 filter_on_reg;

    // datapath registers
    logic [COORD_W-1:0]           coord_u_reg, coord_v_reg, coord_w_reg;
    logic [POS_W-1:0]             pos_reg [3];
    logic [FRAC_W-1:0]            frac_reg [3];
    logic                         neg_reg [3];
    logic [ADDR_W-1:0]            stride_z_reg;
    logic [ADDR_W-1:0]            acc_reg;
    logic [ADDR_W-1:0]            lin_reg;
    logic signed [VALUE_BITS-1:0] centre_reg;
    logic signed [VALUE_BITS-1:0] a_reg;
    logic signed [VALUE_BITS:0]   diff_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic signed [VALUE_BITS-1:0] res_reg;
    logic signed [SAMPLE_W-1:0]   sample_value_reg;

    // voxel store
    logic signed [VALUE_BITS-1:0] voxel_mem [DEPTH];
    logic signed [VALUE_BITS-1:0] mem_rdata_reg;
    logic [ADDR_W-1:0]            mem_addr;
    logic                         mem_we;
    logic                         mem_re;

    // effective dimensions
    logic [DIM_W-1:0] deff [3];

    // shared multiplier
    logic                    mul_en;
    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [P_W-1:0]   prod;

    // axis capture
    logic [CP_W-1:0]   cprod;
    logic              cap_neg;
    logic [CP_W-1:0]   cap_sv;
    logic [POS_W-1:0]  cap_pos;
    logic              cap_en;
    logic [1:0]        cap_ax;

    // current axis
    logic [POS_W-1:0]             ax_pos;
    logic [FRAC_W-1:0]            ax_frac;
    logic                         ax_neg;
    logic [DIM_W-1:0]             ax_dim;
    logic                         lo_half;
    logic                         use_low;
    logic                         use_high;
    logic                         nb_used;
    logic [T_W-1:0]               t_twice;
    logic [T_W-1:0]               t_val;
    logic [ADDR_W-1:0]            stride;
    logic [ADDR_W-1:0]            nb_addr;
    logic signed [VALUE_BITS-1:0] nb_val;
    logic signed [VALUE_BITS-1:0] lerp_a;
    logic signed [VALUE_BITS-1:0] lerp_b;
    logic signed [P_W-1:0]        rnd_full;
    logic signed [SUM_W-1:0]      sum_next;

    // divider
    logic                         div_start;
    logic signed [SUM_W-1:0]      div_y;
    logic                         div_done;
    logic signed [VALUE_BITS-1:0] div_quot;

    logic in_fire;
    logic out_load;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;

    assign deff[0] = eff_dim(dim_x_reg);
    assign deff[1] = eff_dim(dim_y_reg);
    assign deff[2] = eff_dim(dim_z_reg);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_x_reg     <= DIM_RESET;
            dim_y_reg     <= DIM_RESET;
            dim_z_reg     <= DIM_RESET;
            filter_on_reg <= FILTER_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DIM_X:  dim_x_reg     <= cfg_data;
                CFG_DIM_Y:  dim_y_reg     <= cfg_data;
                CFG_DIM_Z:  dim_z_reg     <= cfg_data;
                CFG_FILTER: filter_on_reg <= cfg_data[0];
                default:    ;
            endcase
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_MU:
            begin
                mul_a = MA_W'(coord_u_reg);
                mul_b = MB_W'(deff[0]);
            end
            ST_MV:
            begin
                mul_a = MA_W'(coord_v_reg);
                mul_b = MB_W'(deff[1]);
            end
            ST_MW:
            begin
                mul_a = MA_W'(coord_w_reg);
                mul_b = MB_W'(deff[2]);
            end
            ST_MS:
            begin
                mul_a = MA_W'(deff[0]);
                mul_b = MB_W'(deff[1]);
            end
            ST_MY:
            begin
                mul_a = MA_W'(pos_reg[1]);
                mul_b = MB_W'(deff[0]);
            end
            ST_MZ:
            begin
                mul_a = MA_W'(pos_reg[2]);
                mul_b = MB_W'(stride_z_reg);
            end
            ST_ML:
            begin
                mul_a = MA_W'(diff_reg);
                mul_b = MB_W'(t_val);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    vgfs_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // split coord*dim - 0.5 into cell index and fraction
    assign cprod   = prod[CP_W-1:0];
    assign cap_neg = cprod < CP_W'(HALF_CELL);
    assign cap_sv  = cprod - CP_W'(HALF_CELL);
    assign cap_pos = cap_neg ? '0 : cap_sv[FRAC_W +: POS_W];

    always_comb
    begin
        cap_en = 1'b1;
        cap_ax = AX_X;
        case (state_reg)
            ST_MV:   cap_ax = AX_X;
            ST_MW:   cap_ax = AX_Y;
            ST_MS:   cap_ax = AX_Z;
            default: cap_en = 1'b0;
        endcase
    end

    // neighbour choice for the current axis
    assign ax_pos   = pos_reg[ax_reg];
    assign ax_frac  = frac_reg[ax_reg];
    assign ax_neg   = neg_reg[ax_reg];
    assign ax_dim   = deff[ax_reg];
    assign lo_half  = ax_frac <= FRAC_W'(HALF_CELL);
    assign use_low  = !ax_neg && lo_half && (ax_pos != '0);
    assign use_high = !ax_neg && !lo_half && ((DIM_W'(ax_pos) + DIM_W'(1)) < ax_dim);
    assign nb_used  = use_low || use_high;
    assign t_twice  = {ax_frac, 1'b0};
    assign t_val    = use_high ? (t_twice - T_W'(1 << FRAC_W)) : t_twice;

    always_comb
    begin
        case (ax_reg)
            AX_X:    stride = ADDR_W'(1);
            AX_Y:    stride = ADDR_W'(deff[0]);
            AX_Z:    stride = stride_z_reg;
            default: stride = ADDR_W'(1);
        endcase
    end

    assign nb_addr = use_high ? (lin_reg + stride) : (lin_reg - stride);

    // lerp operands; an unused neighbour is replaced by the centre
    assign nb_val = nb_used ? mem_rdata_reg : centre_reg;
    assign lerp_a = use_high ? centre_reg : nb_val;
    assign lerp_b = use_high ? nb_val : centre_reg;

    // round to nearest, ties up, and accumulate
    assign rnd_full = (prod + P_W'(HALF_CELL)) >>> FRAC_W;
    assign sum_next = sum_reg + SUM_W'(a_reg) + SUM_W'(rnd_full);

    // store port
    assign mem_we = in_fire && (command == CMD_LOAD) && (int'(load_index) < DEPTH);
    assign mem_re = (state_reg == ST_RC) || ((state_reg == ST_RN) && nb_used);

    always_comb
    begin
        case (state_reg)
            ST_IDLE: mem_addr = ADDR_W'(load_index);
            ST_RN:   mem_addr = nb_addr;
            default: mem_addr = lin_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            voxel_mem[mem_addr] <= sat_load(load_value);
        end
        if (mem_re)
        begin
            mem_rdata_reg <= voxel_mem[mem_addr];
        end
    end

    // average of the three axis results
    assign div_start = (state_reg == ST_DV);
    assign div_y     = sum_reg + SUM_W'(1);

    vgfs_div3 #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_y),
        .done     (div_done),
        .quotient (div_quot)
    );

    // result register handoff
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (command == CMD_SAMPLE))
                begin
                    state_next = ST_MU;
                end
            end
            ST_MU: state_next = ST_MV;
            ST_MV: state_next = ST_MW;
            ST_MW: state_next = ST_MS;
            ST_MS: state_next = ST_MY;
            ST_MY: state_next = ST_MZ;
            ST_MZ: state_next = ST_AD;
            ST_AD: state_next = ST_RC;
            ST_RC: state_next = ST_CW;
            ST_CW:
            begin
                ax_next    = AX_X;
                state_next = filter_on_reg ? ST_RN : ST_OUT;
            end
            ST_RN: state_next = ST_DF;
            ST_DF: state_next = ST_ML;
            ST_ML: state_next = ST_AC;
            ST_AC:
            begin
                if (ax_reg == AX_Z)
                begin
                    state_next = ST_DV;
                end
                else
                begin
                    ax_next    = ax_reg + 2'd1;
                    state_next = ST_RN;
                end
            end
            ST_DV: state_next = ST_DW;
            ST_DW:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ax_reg        <= AX_X;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire && (command == CMD_SAMPLE))
        begin
            coord_u_reg <= coord_u;
            coord_v_reg <= coord_v;
            coord_w_reg <= coord_w;
        end
        if (cap_en)
        begin
            pos_reg[cap_ax]  <= cap_pos;
            frac_reg[cap_ax] <= cap_sv[FRAC_W-1:0];
            neg_reg[cap_ax]  <= cap_neg;
        end
        if (state_reg == ST_MY)
        begin
            stride_z_reg <= prod[ADDR_W-1:0];
        end
        if (state_reg == ST_MZ)
        begin
            acc_reg <= prod[ADDR_W-1:0] + ADDR_W'(pos_reg[0]);
        end
        if (state_reg == ST_AD)
        begin
            lin_reg <= acc_reg + prod[ADDR_W-1:0];
        end
        if (state_reg == ST_CW)
        begin
            centre_reg <= mem_rdata_reg;
            res_reg    <= mem_rdata_reg;
            sum_reg    <= '0;
        end
        if (state_reg == ST_DF)
        begin
            a_reg    <= lerp_a;
            diff_reg <= (VALUE_BITS + 1)'(lerp_b) - (VALUE_BITS + 1)'(lerp_a);
        end
        if (state_reg == ST_AC)
        begin
            sum_reg <= sum_next;
        end
        if ((state_reg == ST_DW) && div_done)
        begin
            res_reg <= div_quot;
        end
        if (out_load)
        begin
            sample_value_reg <= SAMPLE_W'(res_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign sample_value = sample_value_reg;

    // a load never produces a result
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_LOAD) && !out_valid) |=> !out_valid)
        else $error("load request produced a result");

    // the divider finishes only while the sequencer waits for it
    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DW))
        else $error("divide finished outside its wait state");

    // a sample request holds off the next request
    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (command == CMD_SAMPLE)) |=> !in_ready)
        else $error("request taken while a sample is in progress");

endmodule

`default_nettype wire

>>> dv/voxel_grid_filtered_sampler_tb.sv
`default_nettype none

module voxel_grid_filtered_sampler_tb;
    import vgfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_ITEMS   = 195;
    localparam int NUM_SETTINGS  = 8;
    localparam int PICK          = -1;
    localparam int CALM_PHASE    = 3;
    localparam int CELL_STEP     = 65536;

    localparam longint VALUE_MAX = (64'sd1 <<< (VGFS_VALUE_BITS - 1)) - 64'sd1;
    localparam longint VALUE_MIN = -VALUE_MAX - 64'sd1;

    // grid settings per phase: dim_x, dim_y, dim_z, filter_on (PICK draws a small size)
    localparam int SETTING_ROWS [NUM_SETTINGS][4] = '{
        '{2, 2, 2, 1},
        '{64, 64, 64, 0},
        '{0, 1, 127, 1},
        '{100, 3, 7, 1},
        '{5, 64, 2, 0},
        '{PICK, PICK, PICK, 1},
        '{PICK, PICK, PICK, 0},
        '{64, 64, 64, 1}
    };

    // predictor of the sampler and store of expected samples
    class sampler_scoreboard;
        longint voxels[int];
        int dim_reg[3];
        bit filter_reg;
        logic signed [SAMPLE_W-1:0] expected_q[$];
        int errors;
        int checked;
        int load_count;
        int sample_count;

        function new();
            dim_reg[0] = int'(DIM_RESET);
            dim_reg[1] = int'(DIM_RESET);
            dim_reg[2] = int'(DIM_RESET);
            filter_reg = FILTER_RESET;
            errors = 0;
            checked = 0;
            load_count = 0;
            sample_count = 0;
        endfunction

        static function int clamp_dim(int d);
            if (d < 2)
                return 2;
            if (d > VGFS_MAX_DIM)
                return VGFS_MAX_DIM;
            return d;
        endfunction

        static function int linear(int q[3], int dims[3]);
            return q[0] + dims[0] * (q[1] + dims[1] * q[2]);
        endfunction

        // voxel position and Q0.16 weight per axis, weight -1 when below half a cell
        static function void place(input logic [COORD_W-1:0] u, v, w, input int dims[3],
                                   output int p[3], output int f[3]);
            logic [COORD_W-1:0] crd[3];
            int s;
            crd[0] = u;
            crd[1] = v;
            crd[2] = w;
            for (int i = 0; i < 3; i++)
            begin
                s = int'(crd[i]) * dims[i] - HALF_CELL;
                if (s < 0)
                begin
                    p[i] = 0;
                    f[i] = -1;
                end
                else
                begin
                    p[i] = s >>> 16;
                    f[i] = s & 'hFFFF;
                end
            end
        endfunction

        // linear indexes of the centre and every in-grid axis neighbour
        static function void list_taps(input logic [COORD_W-1:0] u, v, w, input int dims[3],
                                       output int taps[$]);
            int p[3];
            int f[3];
            int q[3];
            taps.delete();
            place(u, v, w, dims, p, f);
            taps.push_back(linear(p, dims));
            for (int i = 0; i < 3; i++)
            begin
                if (p[i] > 0)
                begin
                    q = p;
                    q[i] = p[i] - 1;
                    taps.push_back(linear(q, dims));
                end
                if (p[i] + 1 < dims[i])
                begin
                    q = p;
                    q[i] = p[i] + 1;
                    taps.push_back(linear(q, dims));
                end
            end
        endfunction

        // a + (b - a) * t with rounding to nearest, ties up
        static function longint blend(longint a, longint b, longint t);
            return a + (((b - a) * t + HALF_CELL) >>> 16);
        endfunction

        static function longint floor_div6(longint x);
            if (x >= 0)
                return x / 6;
            return -((-(x + 1)) / 6) - 1;
        endfunction

        static function longint clip(longint x);
            if (x > VALUE_MAX)
                return VALUE_MAX;
            if (x < VALUE_MIN)
                return VALUE_MIN;
            return x;
        endfunction

        function longint filtered_sample(logic [COORD_W-1:0] u, v, w);
            int dims[3];
            int p[3];
            int f[3];
            int q[3];
            longint centre;
            longint lowv;
            longint highv;
            longint sum;
            for (int i = 0; i < 3; i++)
                dims[i] = clamp_dim(dim_reg[i]);
            place(u, v, w, dims, p, f);
            centre = voxels[linear(p, dims)];
            if (!filter_reg)
                return clip(centre);
            sum = 0;
            // per-axis half-cell lerp, missing neighbours fall back to the centre
            for (int i = 0; i < 3; i++)
            begin
                lowv = centre;
                highv = centre;
                if (p[i] > 0)
                begin
                    q = p;
                    q[i] = p[i] - 1;
                    lowv = voxels[linear(q, dims)];
                end
                if (p[i] + 1 < dims[i])
                begin
                    q = p;
                    q[i] = p[i] + 1;
                    highv = voxels[linear(q, dims)];
                end
                if (f[i] < 0)
                    sum += centre;
                else if (f[i] <= HALF_CELL)
                    sum += blend(lowv, centre, 2 * f[i]);
                else
                    sum += blend(centre, highv, 2 * f[i] - CELL_STEP);
            end
            // average of three, rounded to nearest with ties up
            return clip(floor_div6(2 * sum + 3));
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DIM_X:  dim_reg[0] = int'(data);
                CFG_DIM_Y:  dim_reg[1] = int'(data);
                CFG_DIM_Z:  dim_reg[2] = int'(data);
                CFG_FILTER: filter_reg = data[0];
                default:    ;
            endcase
        endfunction

        function void note_request(logic cmd, logic [LOAD_IDX_W-1:0] idx,
                                   logic signed [LOAD_VAL_W-1:0] val,
                                   logic [COORD_W-1:0] u, v, w);
            if (cmd == CMD_LOAD)
            begin
                voxels[int'(idx)] = clip(longint'(val));
                load_count++;
            end
            else
            begin
                expected_q.push_back(SAMPLE_W'(filtered_sample(u, v, w)));
                sample_count++;
            end
        endfunction

        function void check_result(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            if (expected_q.size() == 0)
            begin
                $error("sample_value: no sample outstanding, expected none, actual %0d", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got !== want)
            begin
                $error("sample_value: expected %0d, actual %0d", want, got);
                errors++;
            end
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    logic                         command = CMD_LOAD;
    logic [LOAD_IDX_W-1:0]        load_index = '0;
    logic signed [LOAD_VAL_W-1:0] load_value = '0;
    logic [COORD_W-1:0]           coord_u = '0;
    logic [COORD_W-1:0]           coord_v = '0;
    logic [COORD_W-1:0]           coord_w = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0]   sample_value;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data = '0;

    sampler_scoreboard sb = new();

    // stimulus side view of the grid and of which voxels hold a value
    int grid[3] = '{64, 64, 64};
    bit planned[int];
    bit calm = 1'b0;
    int sent = 0;
    int cfg_writes = 0;
    int quiet_cycles = 0;

    voxel_grid_filtered_sampler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .load_index   (load_index),
        .load_value   (load_value),
        .coord_u      (coord_u),
        .coord_v      (coord_v),
        .coord_w      (coord_w),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sample_value (sample_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // result side stalls
    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 32);
    end

    // request, result and register traffic into the scoreboard
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.note_config(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_request(command, load_index, load_value, coord_u, coord_v, coord_w);
            if (out_valid && out_ready)
                sb.check_result(sample_value);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [LOAD_VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return LOAD_VAL_W'($urandom_range(0, 511) - 256);
            default: return LOAD_VAL_W'($urandom);
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(int d);
        int slot;
        int s;
        int r;
        slot = $urandom_range(0, d - 1);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return COORD_W'($urandom_range(0, HALF_CELL / d));
            3, 4:
            begin
                // land near a cell edge, a half weight or the top of a cell
                case ($urandom_range(2))
                    0:       s = slot * CELL_STEP;
                    1:       s = slot * CELL_STEP + HALF_CELL;
                    default: s = slot * CELL_STEP + CELL_STEP - 1;
                endcase
                r = (s + HALF_CELL) / d;
                return (r > 65535) ? '1 : COORD_W'(r);
            end
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // one request, held until accepted
    task automatic push_request(input logic cmd, input logic [LOAD_IDX_W-1:0] idx,
                                input logic [LOAD_VAL_W-1:0] val,
                                input logic [COORD_W-1:0] u, v, w);
        while (!calm && $urandom_range(99) < 32)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        command    <= cmd;
        load_index <= idx;
        load_value <= val;
        coord_u    <= u;
        coord_v    <= v;
        coord_w    <= w;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (cmd == CMD_LOAD)
            planned[int'(idx)] = 1'b1;
        sent++;
    endtask

    // fill any voxel the sample will read, then sample
    task automatic sample_at(input logic [COORD_W-1:0] u, v, w);
        int taps[$];
        sampler_scoreboard::list_taps(u, v, w, grid, taps);
        foreach (taps[i])
        begin
            if (!planned.exists(taps[i]))
                push_request(CMD_LOAD, LOAD_IDX_W'(taps[i]), pick_value(),
                             COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
        end
        push_request(CMD_SAMPLE, LOAD_IDX_W'($urandom), LOAD_VAL_W'($urandom), u, v, w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(data);
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_writes++;
    endtask

    task automatic apply_settings(input int dx, dy, dz, input bit f);
        write_reg(CFG_DIM_X, dx);
        write_reg(CFG_DIM_Y, dy);
        write_reg(CFG_DIM_Z, dz);
        // upper data bits are don't-care for the filter flag
        write_reg(CFG_FILTER, {$urandom_range(0, 63), f});
        cfg_valid <= 1'b0;
        grid[0] = sampler_scoreboard::clamp_dim(dx);
        grid[1] = sampler_scoreboard::clamp_dim(dy);
        grid[2] = sampler_scoreboard::clamp_dim(dz);
    endtask

    // hold off until every sample is back and the block has settled
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_phase(input int n);
        int stop;
        int pick;
        stop = sent + n;
        while (sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
                push_request(CMD_LOAD,
                             LOAD_IDX_W'($urandom_range(0, grid[0] * grid[1] * grid[2] - 1)),
                             pick_value(),
                             COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            else if (pick < 28)
                push_request(CMD_LOAD, LOAD_IDX_W'($urandom), pick_value(),
                             COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom));
            else
                sample_at(pick_coord(grid[0]), pick_coord(grid[1]), pick_coord(grid[2]));
        end
    endtask

    initial
    begin
        int dims[3];
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed at reset settings: store ends at the value extremes, then corners,
        // half and zero weights and positions below half a cell
        push_request(CMD_LOAD, '0, 32'h7FFF_FFFF, '0, '0, '0);
        push_request(CMD_LOAD, '1, 32'h8000_0000, '1, '1, '1);
        sample_at('0, '0, '0);
        sample_at('1, '1, '1);
        sample_at(16'd1024, 16'd33792, 16'd512);
        sample_at(16'd300, 16'hFFFF, 16'h8000);
        sample_at(16'd1536, 16'd2047, 16'd1025);
        drain();

        // random phases, one grid setting each
        for (int ph = 0; ph < NUM_SETTINGS; ph++)
        begin
            for (int i = 0; i < 3; i++)
                dims[i] = (SETTING_ROWS[ph][i] == PICK) ? $urandom_range(2, 20)
                                                          : SETTING_ROWS[ph][i];
            apply_settings(dims[0], dims[1], dims[2], SETTING_ROWS[ph][3] != 0);
            calm = (ph == CALM_PHASE);
            random_phase(PHASE_ITEMS / 2);
            drain();
            random_phase(PHASE_ITEMS - PHASE_ITEMS / 2);
            drain();
        end
        calm = 1'b0;

        $display("run covered %0d voxel loads and %0d samples (%0d checked) over %0d settings,",
                 sb.load_count, sb.sample_count, sb.checked, NUM_SETTINGS + 1);
        $display("filter on and off, grid edges, clamped sizes and %0d register writes",
                 cfg_writes);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
